[design/siqd_pkg.sv]
package siqd_pkg;

  localparam int DEPTH       = 64;
  localparam int KEY_BITS    = 32;
  localparam int HANDLE_BITS = 16;
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_CAP,
    S_SCAN,
    S_TAIL,
    S_FRONT_RD,
    S_FRONT_CAP,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic                   we;
    logic [IDX_W-1:0]       addr;
    entry_t                 data;
  } ram_wr_t;

  typedef struct packed {
    status_t                status;
    logic [KEY_BITS-1:0]    popped_key;
    logic [HANDLE_BITS-1:0] popped_handle;
    logic [CNT_W-1:0]       count;
    logic                   is_empty;
    logic [KEY_BITS-1:0]    front_key;
    logic [HANDLE_BITS-1:0] front_handle;
  } result_t;

  // Map a position in queue order onto a RAM row of the ring.
  function automatic logic [IDX_W-1:0] phys_idx(input logic [IDX_W-1:0] head,
                                               input logic [CNT_W-1:0] pos);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(pos);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + IDX_W'(1);
    end
    return res;
  endfunction

endpackage

[design/siqd_if.sv]
interface siqd_in_if;
  import siqd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [KEY_BITS-1:0]    key;
  logic [HANDLE_BITS-1:0] handle;
  modport source (output valid, mode, key, handle, input ready);
  modport sink   (input valid, mode, key, handle, output ready);
endinterface

interface siqd_out_if;
  import siqd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [KEY_BITS-1:0]    popped_key;
  logic [HANDLE_BITS-1:0] popped_handle;
  logic [CNT_W-1:0]       count;
  logic                   is_empty;
  logic [KEY_BITS-1:0]    front_key;
  logic [HANDLE_BITS-1:0] front_handle;
  modport source (output valid, status, popped_key, popped_handle, count, is_empty,
                  front_key, front_handle, input ready);
  modport sink   (input valid, status, popped_key, popped_handle, count, is_empty,
                  front_key, front_handle, output ready);
endinterface

interface siqd_cfg_if;
  logic valid;
  logic ready;
  logic ordered_mode;
  modport source (output valid, ordered_mode, input ready);
  modport sink   (input valid, ordered_mode, output ready);
endinterface

[design/siqd_ram.sv]
module siqd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/siqd_ctrl.sv]
module siqd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  siqd_in_if.sink          in_ch,
  siqd_cfg_if.sink         cfg_ch,
  output logic             res_valid,
  output siqd_pkg::result_t res,
  input  logic             res_ready,
  output siqd_pkg::ram_wr_t ram_wr,
  output logic [siqd_pkg::IDX_W-1:0] ram_raddr,
  input  siqd_pkg::entry_t ram_rdata
);
  import siqd_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic             ordered_r;
  entry_t           new_r, new_nxt;
  entry_t           carry_r, carry_nxt;
  entry_t           popped_r, popped_nxt;
  entry_t           front_r, front_nxt;
  status_t          status_r, status_nxt;
  logic             found_r, found_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] rd_i_r, rd_i_nxt;
  logic [CNT_W-1:0] proc_i;
  logic             stop;
  logic             done;

  assign cfg_ch.ready = 1'b1;
  assign proc_i       = rd_i_r - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      head_r    <= '0;
      ordered_r <= 1'b1;
      found_r   <= 1'b0;
      pend_r    <= 1'b0;
      rd_i_r    <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      head_r  <= head_nxt;
      found_r <= found_nxt;
      pend_r  <= pend_nxt;
      rd_i_r  <= rd_i_nxt;
      if (cfg_ch.valid) begin
        ordered_r <= cfg_ch.ordered_mode;
      end
    end
  end

  always_ff @(posedge clk) begin
    new_r    <= new_nxt;
    carry_r  <= carry_nxt;
    popped_r <= popped_nxt;
    front_r  <= front_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    head_nxt    = head_r;
    new_nxt     = new_r;
    carry_nxt   = carry_r;
    popped_nxt  = popped_r;
    front_nxt   = front_r;
    status_nxt  = status_r;
    found_nxt   = found_r;
    pend_nxt    = pend_r;
    rd_i_nxt    = rd_i_r;
    ram_wr.we   = 1'b0;
    ram_wr.addr = phys_idx(head_r, count_r);
    ram_wr.data = new_r;
    ram_raddr   = head_r;
    in_ch.ready = 1'b0;
    res_valid   = 1'b0;
    stop        = 1'b0;
    done        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          new_nxt    = '{key: in_ch.key, handle: in_ch.handle};
          status_nxt = ST_OK;
          popped_nxt = '0;
          found_nxt  = 1'b0;
          pend_nxt   = 1'b0;
          rd_i_nxt   = '0;
          if (in_ch.mode == OP_POP) begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_FRONT_RD;
            end else begin
              // head row read is issued this cycle
              state_nxt = S_POP_CAP;
            end
          end else if (ordered_r && count_r != '0) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_TAIL;
          end
        end
      end

      S_POP_CAP: begin
        popped_nxt = ram_rdata;
        head_nxt   = next_idx(head_r);
        count_nxt  = count_r - CNT_W'(1);
        state_nxt  = S_FRONT_RD;
      end

      S_SCAN: begin
        // Walk forward; once the slot is found, ripple each entry one row up.
        if (pend_r) begin
          ram_wr.addr = phys_idx(head_r, proc_i);
          if (found_r) begin
            ram_wr.we   = 1'b1;
            ram_wr.data = carry_r;
            carry_nxt   = ram_rdata;
          end else if (ram_rdata.key == new_r.key) begin
            status_nxt = ST_DUP;
            stop       = 1'b1;
          end else if (ram_rdata.key > new_r.key) begin
            if (count_r == CNT_W'(DEPTH)) begin
              status_nxt = ST_FULL;
              stop       = 1'b1;
            end else begin
              ram_wr.we   = 1'b1;
              ram_wr.data = new_r;
              found_nxt   = 1'b1;
              carry_nxt   = ram_rdata;
            end
          end
          if (!stop && rd_i_r == count_r) begin
            done = 1'b1;
          end
        end
        if (stop) begin
          pend_nxt  = 1'b0;
          state_nxt = S_FRONT_RD;
        end else if (done) begin
          pend_nxt  = 1'b0;
          state_nxt = S_TAIL;
        end else begin
          ram_raddr = phys_idx(head_r, rd_i_r);
          rd_i_nxt  = rd_i_r + CNT_W'(1);
          pend_nxt  = 1'b1;
        end
      end

      S_TAIL: begin
        ram_wr.addr = phys_idx(head_r, count_r);
        if (found_r) begin
          ram_wr.we   = 1'b1;
          ram_wr.data = carry_r;
          count_nxt   = count_r + CNT_W'(1);
        end else if (count_r == CNT_W'(DEPTH)) begin
          status_nxt = ST_FULL;
        end else begin
          ram_wr.we   = 1'b1;
          ram_wr.data = new_r;
          count_nxt   = count_r + CNT_W'(1);
        end
        state_nxt = S_FRONT_RD;
      end

      S_FRONT_RD: begin
        ram_raddr = head_r;
        state_nxt = S_FRONT_CAP;
      end

      S_FRONT_CAP: begin
        front_nxt = (count_r == '0) ? entry_t'('0) : ram_rdata;
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.status        = status_r;
    res.popped_key    = popped_r.key;
    res.popped_handle = popped_r.handle;
    res.count         = count_r;
    res.is_empty      = (count_r == '0);
    res.front_key     = front_r.key;
    res.front_handle  = front_r.handle;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP_CAP |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("pop did not retire one entry");

  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr.we |-> (state_r == S_SCAN || state_r == S_TAIL))
    else $error("entry RAM written outside insert phases");

  a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && pend_r) |-> (rd_i_r != '0 && rd_i_r <= count_r))
    else $error("scan index out of range");

endmodule

[design/siqd_out_stage.sv]
module siqd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  siqd_pkg::result_t res,
  output logic              res_ready,
  siqd_out_if.source        out_ch
);
  import siqd_pkg::*;

  logic    valid_r;
  result_t data_r;

  assign res_ready = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  // hold the beat until taken
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      data_r <= res;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.status        = data_r.status;
  assign out_ch.popped_key    = data_r.popped_key;
  assign out_ch.popped_handle = data_r.popped_handle;
  assign out_ch.count         = data_r.count;
  assign out_ch.is_empty      = data_r.is_empty;
  assign out_ch.front_key     = data_r.front_key;
  assign out_ch.front_handle  = data_r.front_handle;

endmodule

[design/sorted_insert_queue_dedup.sv]
// channel  dir  handshake      beat
// in_ch    in   valid/ready    mode, key, handle
// out_ch   out  valid/ready    status, popped/front entry, count, is_empty
// cfg_ch   in   valid/ready    ordered_mode (ready always high)
//
// Entries live in a ring in one RAM (registered read, one read and one write port).
// Pop (S_POP_CAP) and FIFO push (S_TAIL) pass S_FRONT_RD, S_FRONT_CAP, S_EMIT.
// Ordered push scans in S_SCAN first: the scan visits one stored entry a
// cycle through the RAM read port while shifting later entries one row up.
// Reset clears count, head and mode (ordered); RAM contents need no clearing.
// A stalled out_ch holds the result; one more item may finish behind it.
module sorted_insert_queue_dedup (
  input  logic       clk,
  input  logic       rst_n,
  siqd_in_if.sink    in_ch,
  siqd_out_if.source out_ch,
  siqd_cfg_if.sink   cfg_ch
);
  import siqd_pkg::*;

  logic             res_valid;
  logic             res_ready;
  result_t          res;
  ram_wr_t          ram_wr;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;

  siqd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .ram_wr    (ram_wr),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  siqd_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  siqd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_ch    (out_ch)
  );

endmodule
